### sv/button_click_classifier_core_macros.svh
// assertion macros for the button click classifier
`ifndef BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH
`define BUTTON_CLICK_CLASSIFIER_CORE_MACROS_SVH

// checked only outside reset
`define BCC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bcc assertion failed");

// checked also while reset is applied
`define BCC_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("bcc assertion failed");

`endif

### sv/bcc_pkg.sv
// types and constants shared by the button click classifier files
`timescale 1ns / 1ps

package bcc_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int KIND_W     = 2;

    typedef logic [KIND_W-1:0]     kind_t;
    typedef logic [TIME_W-1:0]     time_t;
    typedef logic [CFG_DATA_W-1:0] cfg_data_t;
    typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

    localparam kind_t KIND_NONE   = 2'd0;
    localparam kind_t KIND_SHORT  = 2'd1;
    localparam kind_t KIND_LONG   = 2'd2;
    localparam kind_t KIND_DOUBLE = 2'd3;

    localparam cfg_idx_t REG_LONG_PRESS   = 2'd0;
    localparam cfg_idx_t REG_SHORT_PRESS  = 2'd1;
    localparam cfg_idx_t REG_DOUBLE_WIN   = 2'd2;

    localparam cfg_data_t LONG_PRESS_RST  = 16'd1000;
    localparam cfg_data_t SHORT_PRESS_RST = 16'd50;
    localparam cfg_data_t DOUBLE_WIN_RST  = 16'd300;

endpackage

### sv/bcc_if.sv
// handshake channels of the button click classifier
`timescale 1ns / 1ps

interface bcc_sample_if;
    logic          valid;
    logic          ready;
    logic          button_down;
    bcc_pkg::time_t now_ms;

    modport source (output valid, output button_down, output now_ms, input ready);
    modport sink (input valid, input button_down, input now_ms, output ready);
endinterface

interface bcc_click_if;
    logic          valid;
    logic          ready;
    bcc_pkg::kind_t click_kind;

    modport source (output valid, output click_kind, input ready);
    modport sink (input valid, input click_kind, output ready);
endinterface

interface bcc_cfg_if;
    logic              valid;
    logic              ready;
    bcc_pkg::cfg_idx_t  index;
    bcc_pkg::cfg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### sv/button_click_classifier_core.sv
// button click classifier: short, long and double click detection
//
//  channel  | dir | payload
//  ---------+-----+-------------------------------
//  sample   | in  | button_down, now_ms
//  click    | out | click_kind
//  cfg      | in  | index, data (always ready)
//
//  one item per cycle while the click channel takes results (input register, result register)
//  the state update and classification sit between the two registers
//  a stalled click channel holds the result; the input register still takes
//  one more item, then sample.ready drops until the result is taken
//  reset clears both valid flags, the click state and the thresholds to defaults
`timescale 1ns / 1ps

module button_click_classifier_core (
    input  logic           clk,
    input  logic           rst_n,
    bcc_sample_if.sink     sample,
    bcc_click_if.source    click,
    bcc_cfg_if.sink        cfg
);

    logic               s1_valid_reg;
    logic               s1_down_reg;
    bcc_pkg::time_t     s1_now_reg;

    logic               out_valid_reg;
    bcc_pkg::kind_t     out_kind_reg;
    bcc_pkg::kind_t     out_kind_next;

    bcc_pkg::cfg_data_t long_press_reg;
    bcc_pkg::cfg_data_t short_press_reg;
    bcc_pkg::cfg_data_t double_win_reg;

    bcc_pkg::time_t     press_start_reg;
    bcc_pkg::time_t     press_start_next;
    bcc_pkg::time_t     release_reg;
    bcc_pkg::time_t     release_next;
    logic               was_pressed_reg;
    logic               was_pressed_next;
    logic               pending_reg;
    logic               pending_next;

    logic               out_load;
    logic               advance;
    bcc_pkg::time_t     dur;
    bcc_pkg::time_t     gap;
    logic               gap_in_window;

    assign out_load     = !out_valid_reg || click.ready;
    assign advance      = s1_valid_reg && out_load;
    assign sample.ready = !s1_valid_reg || out_load;
    assign cfg.ready    = 1'b1;

    assign click.valid      = out_valid_reg;
    assign click.click_kind = out_kind_reg;

    assign dur           = s1_now_reg - press_start_reg;
    assign gap           = s1_now_reg - release_reg;
    assign gap_in_window = gap <= {{(bcc_pkg::TIME_W-bcc_pkg::CFG_DATA_W){1'b0}}, double_win_reg};

    always_comb
    begin
        out_kind_next    = bcc_pkg::KIND_NONE;
        press_start_next = press_start_reg;
        release_next     = release_reg;
        was_pressed_next = s1_down_reg;
        pending_next     = pending_reg;
        if (s1_down_reg)
        begin
            if (!was_pressed_reg)
            begin
                press_start_next = s1_now_reg;
            end
        end
        else if (was_pressed_reg)
        begin
            if (dur >= {{(bcc_pkg::TIME_W-bcc_pkg::CFG_DATA_W){1'b0}}, long_press_reg})
            begin
                out_kind_next = bcc_pkg::KIND_LONG;
            end
            else if (dur >= {{(bcc_pkg::TIME_W-bcc_pkg::CFG_DATA_W){1'b0}}, short_press_reg})
            begin
                if (pending_reg && gap_in_window)
                begin
                    out_kind_next = bcc_pkg::KIND_DOUBLE;
                    pending_next  = 1'b0;
                end
                else
                begin
                    out_kind_next = bcc_pkg::KIND_SHORT;
                    pending_next  = 1'b1;
                end
            end
            release_next = s1_now_reg;
        end
        // a release resets the gap to zero, so expiry only applies without one
        if (!(!s1_down_reg && was_pressed_reg) && pending_reg && !gap_in_window)
        begin
            pending_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            press_start_reg <= '0;
            release_reg     <= '0;
            was_pressed_reg <= 1'b0;
            pending_reg     <= 1'b0;
            long_press_reg  <= bcc_pkg::LONG_PRESS_RST;
            short_press_reg <= bcc_pkg::SHORT_PRESS_RST;
            double_win_reg  <= bcc_pkg::DOUBLE_WIN_RST;
        end
        else
        begin
            if (sample.ready)
            begin
                s1_valid_reg <= sample.valid;
            end
            if (out_load)
            begin
                out_valid_reg <= s1_valid_reg;
            end
            if (advance)
            begin
                press_start_reg <= press_start_next;
                release_reg     <= release_next;
                was_pressed_reg <= was_pressed_next;
                pending_reg     <= pending_next;
            end
            if (cfg.valid)
            begin
                case (cfg.index)
                    bcc_pkg::REG_LONG_PRESS:  long_press_reg  <= cfg.data;
                    bcc_pkg::REG_SHORT_PRESS: short_press_reg <= cfg.data;
                    bcc_pkg::REG_DOUBLE_WIN:  double_win_reg  <= cfg.data;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_down_reg <= sample.button_down;
            s1_now_reg  <= sample.now_ms;
        end
        if (advance)
        begin
            out_kind_reg <= out_kind_next;
        end
    end

endmodule

### sv/bcc_checker.sv
// port-level checks for the button click classifier, bound to the core module
`timescale 1ns / 1ps
`include "button_click_classifier_core_macros.svh"

module bcc_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           sample_valid,
    input logic           sample_ready,
    input logic           sample_down,
    input logic           click_valid,
    input logic           click_ready,
    input bcc_pkg::kind_t click_kind,
    input logic           cfg_valid,
    input logic           cfg_ready
);

    // a stalled result holds
    `BCC_ASSERT(a_click_hold, click_valid && !click_ready |=> click_valid && $stable(click_kind))

    // a pressed sample reaches the output as no click when the output drains while it sits in the input register
    `BCC_ASSERT(a_press_no_click,
        (sample_valid && sample_ready && sample_down) ##1 click_ready |=>
        click_valid && click_kind == bcc_pkg::KIND_NONE)

    // an empty output never holds back the input
    `BCC_ASSERT(a_ready_when_empty, !click_valid |-> sample_ready && (!cfg_valid || cfg_ready))

    // reset empties the output
    `BCC_ASSERT_ALWAYS(a_reset_empty, !rst_n |-> !click_valid)

endmodule

bind button_click_classifier_core bcc_checker u_bcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample.valid),
    .sample_ready (sample.ready),
    .sample_down  (sample.button_down),
    .click_valid  (click.valid),
    .click_ready  (click.ready),
    .click_kind   (click.click_kind),
    .cfg_valid    (cfg.valid),
    .cfg_ready    (cfg.ready)
);
